// ===== src/jpeg_sof_dimension_scanner_defines.svh =====
// Assertion macros for the checker file of the SOF dimension scanner.
`ifndef JPEG_SOF_DIMENSION_SCANNER_DEFINES_SVH
`define JPEG_SOF_DIMENSION_SCANNER_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define JSS_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("%m: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define JSS_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("%m: next-cycle check failed");

`endif

// ===== src/jss_pkg.sv =====
package jss_pkg;

   // Byte values that the scanner looks for.
   localparam logic [7:0] BYTE_FF   = 8'hFF;
   localparam logic [7:0] BYTE_SOI  = 8'hD8;
   localparam logic [7:0] BYTE_SOS  = 8'hDA;
   localparam logic [7:0] SOF_LOW   = 8'hC0;
   localparam logic [7:0] SOF_HIGH  = 8'hCF;
   localparam logic [7:0] BYTE_DHT  = 8'hC4;
   localparam logic [7:0] BYTE_JPG  = 8'hC8;
   localparam logic [7:0] BYTE_DAC  = 8'hCC;

   // Bytes skipped between an SOF marker and the height field.
   localparam logic [1:0] SKIP_LAST = 2'd3;

   // Result status codes.
   localparam logic [1:0] ST_FOUND   = 2'd0;
   localparam logic [1:0] ST_NOTJPEG = 2'd1;
   localparam logic [1:0] ST_SOS     = 2'd2;
   localparam logic [1:0] ST_EARLY   = 2'd3;

   // One input word.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       first_byte;
      logic       last_byte;
   } req_word_type;

   // One result word.
   typedef struct packed {
      logic [1:0]  scan_status;
      logic [15:0] image_height;
      logic [15:0] image_width;
   } result_type;

   // Result handed from the scan core to the output register.
   typedef struct packed {
      logic       valid;
      result_type data;
   } result_ctl_type;

   // True for a start-of-frame marker code.
   function automatic logic is_sof(input logic [7:0] code);
      logic in_range;
      in_range = (code >= SOF_LOW) && (code <= SOF_HIGH);
      return in_range && (code != BYTE_DHT) && (code != BYTE_JPG) && (code != BYTE_DAC);
   endfunction

endpackage

// ===== src/jss_in_reg.sv =====
module jss_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  jss_pkg::req_word_type req_word,
   input  logic                  advance,
   output logic                  word_valid,
   output jss_pkg::req_word_type word
);
   import jss_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;

   // The register takes a new word when empty or when its word moves on.
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload needs no reset.
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         word_ff <= req_word;
      end
   end

   assign word_valid = valid_ff;
   assign word       = word_ff;

endmodule

// ===== src/jss_scan_core.sv =====
module jss_scan_core (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_valid,
   input  jss_pkg::req_word_type   item,
   output jss_pkg::result_ctl_type result
);
   import jss_pkg::*;

   // Scan phase codes.
   localparam logic [2:0] PH_SOI0   = 3'd0;
   localparam logic [2:0] PH_SOI1   = 3'd1;
   localparam logic [2:0] PH_SEARCH = 3'd2;
   localparam logic [2:0] PH_MARKER = 3'd3;
   localparam logic [2:0] PH_SKIP   = 3'd4;
   localparam logic [2:0] PH_DIMS   = 3'd5;
   localparam logic [2:0] PH_DONE   = 3'd6;

   logic [2:0]  phase_ff, phase_in, phase_cur;
   logic [1:0]  count_ff, count_in, count_cur;
   logic [15:0] height_ff, height_in;
   logic [7:0]  width_hi_ff, width_hi_in;
   logic        done;
   logic        idle;

   // Next state and result for the word at the input register.
   always_comb begin
      phase_cur   = item.first_byte ? PH_SOI0 : phase_ff;
      count_cur   = item.first_byte ? 2'd0 : count_ff;
      phase_in    = phase_ff;
      count_in    = count_ff;
      height_in   = height_ff;
      width_hi_in = width_hi_ff;
      done        = 1'b0;
      idle        = 1'b0;
      result      = '0;
      result.data.scan_status = ST_FOUND;
      if (item_valid) begin
         phase_in = phase_cur;
         count_in = count_cur;
         unique case (phase_cur)
            PH_SOI0: begin
               if (item.data_byte != BYTE_FF) begin
                  done = 1'b1;
                  result.data.scan_status = ST_NOTJPEG;
               end else begin
                  phase_in = PH_SOI1;
               end
            end
            PH_SOI1: begin
               if (item.data_byte != BYTE_SOI) begin
                  done = 1'b1;
                  result.data.scan_status = ST_NOTJPEG;
               end else begin
                  phase_in = PH_SEARCH;
               end
            end
            PH_SEARCH: begin
               if (item.data_byte == BYTE_FF) begin
                  phase_in = PH_MARKER;
               end
            end
            PH_MARKER: begin
               // Fill bytes keep the marker phase.
               priority if (item.data_byte == BYTE_FF) begin
                  phase_in = PH_MARKER;
               end else if (item.data_byte == BYTE_SOS) begin
                  done = 1'b1;
                  result.data.scan_status = ST_SOS;
               end else if (is_sof(item.data_byte)) begin
                  phase_in = PH_SKIP;
                  count_in = 2'd0;
               end else begin
                  phase_in = PH_SEARCH;
               end
            end
            PH_SKIP: begin
               count_in = count_cur + 2'd1;
               if (count_in == SKIP_LAST) begin
                  phase_in = PH_DIMS;
                  count_in = 2'd0;
               end
            end
            PH_DIMS: begin
               // Height high, height low, width high, width low.
               count_in = count_cur + 2'd1;
               unique case (count_cur)
                  2'd0: height_in   = {item.data_byte, 8'h00};
                  2'd1: height_in   = {height_ff[15:8], item.data_byte};
                  2'd2: width_hi_in = item.data_byte;
                  default: begin
                     done = 1'b1;
                     result.data.scan_status  = ST_FOUND;
                     result.data.image_height = height_ff;
                     result.data.image_width  = {width_hi_ff, item.data_byte};
                  end
               endcase
            end
            default: begin
               // After a result, bytes are dropped until the next first byte.
               idle = 1'b1;
            end
         endcase
         // A final byte that completes nothing ends the file early.
         if (!done && !idle && item.last_byte) begin
            done = 1'b1;
            result.data.scan_status = ST_EARLY;
         end
         if (done) begin
            phase_in = PH_DONE;
         end
      end
      result.valid = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SOI0;
         count_ff <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
   end

   // Dimension bytes are always written before they are read.
   always_ff @(posedge clock) begin
      height_ff   <= height_in;
      width_hi_ff <= width_hi_in;
   end

endmodule

// ===== src/jss_out_reg.sv =====
module jss_out_reg (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    load,
   input  jss_pkg::result_ctl_type result,
   output logic                    slot_free,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [31:0]             rsp_tdata,
   output logic [1:0]              rsp_tuser
);
   import jss_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   // The register can be written when empty or when its word leaves now.
   assign slot_free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (slot_free) begin
         valid_in = load && result.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (slot_free && load && result.valid) begin
         data_ff <= result.data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {data_ff.image_width, data_ff.image_height};
   assign rsp_tuser  = data_ff.scan_status;

endmodule

// ===== src/jpeg_sof_dimension_scanner.sv =====
// A taken byte is held in the input register until the output register can take
// its result. Throughput: one byte per cycle while the result side accepts; the
// only loop is the update of the scan phase and the dimension registers.
// Reset (synchronous, active high) clears both valid flags and returns the scan to
// the first signature byte, so a byte after reset counts as a file's first byte.
module jpeg_sof_dimension_scanner (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] first_byte
   input  logic        req_tlast,   // last_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] image_height, [31:16] image_width
   output logic [1:0]  rsp_tuser    // [1:0] scan_status
);
   import jss_pkg::*;

   req_word_type   req_word;
   req_word_type   word;
   logic           word_valid;
   logic           advance;
   logic           slot_free;
   result_ctl_type result;

   assign req_word.data_byte  = req_tdata;
   assign req_word.first_byte = req_tuser;
   assign req_word.last_byte  = req_tlast;

   // A word is processed when the output register can take its result.
   assign advance = word_valid && slot_free;

   jss_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_word),
      .advance    (advance),
      .word_valid (word_valid),
      .word       (word)
   );

   jss_scan_core u_scan_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (advance),
      .item       (word),
      .result     (result)
   );

   jss_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== src/jss_checker.sv =====
`include "jpeg_sof_dimension_scanner_defines.svh"

module jss_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   import jss_pkg::*;

   logic rsp_stall;
   logic in_fire;

   // Handshake terms used by the checks below.
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign in_fire   = req_tvalid && req_tready;

   // A stalled result word holds its value.
   `JSS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable({rsp_tdata, rsp_tuser}))

   // Only a found result carries dimensions.
   `JSS_ASSERT_IMPLY(a_dims_zero, clock, reset, rsp_tvalid && (rsp_tuser != ST_FOUND), rsp_tdata == 32'd0)

   // Out of reset the block is empty and ready for a word.
   `JSS_ASSERT_IMPLY(a_reset_empty, clock, reset, $past(reset), !rsp_tvalid && req_tready)

   // A new result needs an earlier word handshake on the input side.
   `JSS_ASSERT_IMPLY(a_rsp_cause, clock, reset, $rose(rsp_tvalid) && !$past(reset, 2), $past(in_fire, 2))

endmodule

bind jpeg_sof_dimension_scanner jss_checker u_jss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/testbench.sv =====
module testbench;
   import jss_pkg::*;

   // Marker codes used by the directed files.
   localparam logic [7:0] MARK_SOF0 = 8'hC0;
   localparam logic [7:0] MARK_SOF2 = 8'hC2;

   // Stop sending random files once this many words have gone in.
   localparam int WORD_TARGET = 880;

   // Cycles to wait after the last awaited result before finishing.
   localparam int SETTLE_CYCLES = 8;

   // Phases of the byte scan, tracked alongside the block.
   typedef enum logic [2:0] {
      PH_SOI0,
      PH_SOI1,
      PH_SEARCH,
      PH_MARKER,
      PH_SKIP,
      PH_DIMS,
      PH_DONE
   } scan_phase_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tuser;   // [0] first_byte
   logic        req_tlast;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [15:0] image_height, [31:16] image_width
   logic [1:0]  rsp_tuser;   // [1:0] scan_status

   // Scan state mirrored from the accepted bytes.
   scan_phase_type track_phase;
   logic [2:0]  track_count;
   logic [15:0] track_height;
   logic [15:0] track_width;

   // Scan results still to come out of the block, oldest first.
   result_type  awaited_scans[$];

   // Words of the file being built, sent in order.
   req_word_type file_words[$];

   int          mismatches;
   int          words_sent;
   bit          send_gaps;
   bit          recv_stalls;

   jpeg_sof_dimension_scanner dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // Free-running clock with a period of 10.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // True for marker codes that open a start-of-frame segment.
   function automatic bit is_frame_marker(input logic [7:0] code);
      return code >= SOF_LOW && code <= SOF_HIGH &&
             code != BYTE_DHT && code != BYTE_JPG && code != BYTE_DAC;
   endfunction

   // Queue one scan result and close the file.
   task automatic post_scan(input logic [1:0] status, input logic [15:0] height,
                            input logic [15:0] width);
      result_type r;
      r.scan_status  = status;
      r.image_height = height;
      r.image_width  = width;
      awaited_scans.push_back(r);
      track_phase = PH_DONE;
   endtask

   // Advance the mirrored scan by one accepted word.
   task automatic track_byte(input req_word_type w);
      bit finished;
      finished = 1'b0;
      if (w.first_byte) begin
         track_phase  = PH_SOI0;
         track_count  = '0;
         track_height = '0;
         track_width  = '0;
      end
      case (track_phase)
         PH_SOI0: begin
            if (w.data_byte != BYTE_FF) begin
               post_scan(ST_NOTJPEG, '0, '0);
               finished = 1'b1;
            end else begin
               track_phase = PH_SOI1;
            end
         end
         PH_SOI1: begin
            if (w.data_byte != BYTE_SOI) begin
               post_scan(ST_NOTJPEG, '0, '0);
               finished = 1'b1;
            end else begin
               track_phase = PH_SEARCH;
            end
         end
         PH_SEARCH: begin
            if (w.data_byte == BYTE_FF) track_phase = PH_MARKER;
         end
         PH_MARKER: begin
            // Further FF bytes are padding in front of the marker code.
            if (w.data_byte == BYTE_SOS) begin
               post_scan(ST_SOS, '0, '0);
               finished = 1'b1;
            end else if (is_frame_marker(w.data_byte)) begin
               track_phase = PH_SKIP;
               track_count = '0;
            end else if (w.data_byte != BYTE_FF) begin
               track_phase = PH_SEARCH;
            end
         end
         PH_SKIP: begin
            track_count = track_count + 3'd1;
            if (track_count >= SKIP_LAST) begin
               track_phase = PH_DIMS;
               track_count = '0;
            end
         end
         PH_DIMS: begin
            // Height then width, each high byte first.
            case (track_count)
               3'd0: track_height = {w.data_byte, 8'h00};
               3'd1: track_height[7:0] = w.data_byte;
               3'd2: track_width = {w.data_byte, 8'h00};
               default: begin
                  track_width[7:0] = w.data_byte;
                  post_scan(ST_FOUND, track_height, track_width);
                  finished = 1'b1;
               end
            endcase
            track_count = track_count + 3'd1;
         end
         default: return;
      endcase
      if (!finished && w.last_byte) post_scan(ST_EARLY, '0, '0);
   endtask

   // Count one mismatch and print a line for it, for the first 50 only.
   task automatic report(input string what, input int got, input int want);
      mismatches++;
      if (mismatches <= 50)
         $display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
   endtask

   // Send one word, with an occasional idle burst in front of it when gaps are enabled.
   task automatic send_word(input req_word_type w);
      if (send_gaps && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 16) - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = w.data_byte;
      req_tuser  = w.first_byte;
      req_tlast  = w.last_byte;
      do @(posedge clock); while (!req_tready);
      track_byte(w);
      words_sent++;
   endtask

   task automatic add_byte(input logic [7:0] d, input logic first, input logic last);
      req_word_type w;
      w.data_byte  = d;
      w.first_byte = first;
      w.last_byte  = last;
      file_words.push_back(w);
   endtask

   task automatic send_file();
      foreach (file_words[i]) send_word(file_words[i]);
      file_words.delete();
   endtask

   // Hold the input side until every awaited result has come out.
   task automatic wait_all_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_scans.size() != 0) @(negedge clock);
   endtask

   // Random byte that favors the two extremes.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Build one random file: mostly well-formed, some broken or pure noise.
   task automatic make_file();
      int kind;
      int keep;
      logic [7:0] m;
      file_words.delete();
      kind = $urandom_range(0, 15);
      if (kind == 0) begin
         repeat ($urandom_range(1, 10))
            add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0,
                     $urandom_range(0, 7) == 0);
         return;
      end
      if (kind == 1) begin
         add_byte(pick_byte(), 1'b1, 1'b0);
         add_byte(pick_byte(), 1'b0, 1'b0);
      end else begin
         add_byte(BYTE_FF, 1'b1, 1'b0);
         add_byte(BYTE_SOI, 1'b0, 1'b0);
      end
      // Segments with other markers, padded and followed by payload bytes.
      repeat ($urandom_range(0, 3)) begin
         repeat ($urandom_range(1, 3)) add_byte(BYTE_FF, 1'b0, 1'b0);
         do m = 8'($urandom_range(0, 254));
         while (is_frame_marker(m) || m == BYTE_SOS);
         add_byte(m, 1'b0, 1'b0);
         repeat ($urandom_range(0, 4)) add_byte(8'($urandom_range(0, 254)), 1'b0, 1'b0);
      end
      add_byte(BYTE_FF, 1'b0, 1'b0);
      if (kind == 2) begin
         add_byte(BYTE_SOS, 1'b0, 1'b0);
      end else begin
         do m = 8'($urandom_range(SOF_LOW, SOF_HIGH));
         while (!is_frame_marker(m));
         add_byte(m, 1'b0, 1'b0);
         repeat (7) add_byte(pick_byte(), 1'b0, 1'b0);
      end
      repeat ($urandom_range(0, 2)) add_byte(pick_byte(), 1'b0, 1'b0);
      // Truncated files end early; some files are cut off by the next first mark.
      if (kind == 3) begin
         keep = $urandom_range(1, file_words.size());
         while (file_words.size() > keep) void'(file_words.pop_back());
      end
      if (kind != 4) file_words[file_words.size() - 1].last_byte = 1'b1;
   endtask

   // A file right after reset carries no first mark; FF padding precedes the
   // marker, and the word that completes the result also carries the last mark.
   task automatic test_no_first_mark();
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(BYTE_SOI, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(MARK_SOF2, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'h11, 1'b0, 1'b0);
      add_byte(8'h22, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'hFF, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b0);
      add_byte(8'h00, 1'b0, 1'b1);
      send_file();
   endtask

   // Wrong first and wrong second signature byte; bytes after a result are ignored.
   task automatic test_bad_signature();
      add_byte(8'h00, 1'b1, 1'b0);
      add_byte(8'h55, 1'b0, 1'b1);
      add_byte(BYTE_FF, 1'b1, 1'b0);
      add_byte(8'h12, 1'b0, 1'b0);
      send_file();
   endtask

   // The excluded codes in the frame range do not start a frame; SOS ends the scan.
   task automatic test_sos_and_excluded_markers();
      add_byte(BYTE_FF, 1'b1, 1'b0);
      add_byte(BYTE_SOI, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(BYTE_DHT, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(BYTE_DAC, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(BYTE_JPG, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(BYTE_SOS, 1'b0, 1'b0);
      send_file();
   endtask

   // A first mark in the middle of a frame restarts; the new file ends early.
   task automatic test_early_end_and_restart();
      add_byte(BYTE_FF, 1'b1, 1'b0);
      add_byte(BYTE_SOI, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b0, 1'b0);
      add_byte(MARK_SOF0, 1'b0, 1'b0);
      add_byte(BYTE_FF, 1'b1, 1'b0);
      add_byte(BYTE_SOI, 1'b0, 1'b1);
      send_file();
      wait_all_results();
   endtask

   // Random files, with idling switched per batch and an occasional drain.
   task automatic test_random_files();
      int files;
      files = 0;
      while (words_sent < WORD_TARGET) begin
         if (files % 12 == 0) begin
            send_gaps   = $urandom_range(0, 3) != 0;
            recv_stalls = $urandom_range(0, 3) != 0;
         end
         if (files % 30 == 29) wait_all_results();
         make_file();
         send_file();
         files++;
      end
   endtask

   // Back-to-back files at full rate on both sides.
   task automatic test_full_rate_tail();
      send_gaps   = 1'b0;
      recv_stalls = 1'b0;
      repeat (15) begin
         make_file();
         send_file();
      end
   endtask

   // Result side: random stall bursts while enabled.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (recv_stalls && $urandom_range(0, 7) == 0) begin
            rsp_tready = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clock);
         end
         rsp_tready = 1'b1;
      end
   end

   // Compare every accepted result word with the oldest awaited scan.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_scans.size() == 0) begin
            report("result with none awaited, status", int'(rsp_tuser), 0);
         end else begin
            want = awaited_scans.pop_front();
            if (rsp_tuser != want.scan_status)
               report("scan_status", int'(rsp_tuser), int'(want.scan_status));
            if (rsp_tdata[15:0] != want.image_height)
               report("image_height", int'(rsp_tdata[15:0]), int'(want.image_height));
            if (rsp_tdata[31:16] != want.image_width)
               report("image_width", int'(rsp_tdata[31:16]), int'(want.image_width));
         end
      end
   end

   // Main sequence.
   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = 1'b0;
      req_tlast    = 1'b0;
      mismatches   = 0;
      words_sent   = 0;
      send_gaps    = 1'b1;
      recv_stalls  = 1'b1;
      track_phase  = PH_SOI0;
      track_count  = '0;
      track_height = '0;
      track_width  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_no_first_mark();
      test_bad_signature();
      test_sos_and_excluded_markers();
      test_early_end_and_restart();
      test_random_files();
      test_full_rate_tail();

      @(negedge clock);
      req_tvalid = 1'b0;
      while (awaited_scans.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && awaited_scans.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
